// ===== design/nsrj_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nsrj_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    // 'a' minus ten, for hex digits above nine
    localparam logic [7:0] CH_HEX_AL = 8'h57;

    localparam int unsigned MAX_RUN = 8;
    localparam int unsigned RUN_W   = $clog2(MAX_RUN + 1);
    localparam int unsigned IDX_W   = $clog2(MAX_RUN);

    // what follows the prefix bytes of a word
    typedef enum logic [2:0] {
        BODY_NONE    = 3'd0,
        BODY_RAW     = 3'd1,
        BODY_ESC2    = 3'd2,
        BODY_UHEX    = 3'd3,
        BODY_KEY_END = 3'd4,
        BODY_VAL_END = 3'd5
    } t_body;

    typedef struct packed {
        logic       lbrace;
        logic       close;
        logic       comma;
        logic       open_quote;
        t_body      body;
        logic [7:0] data;
    } t_cmd;

    // second byte of a two-byte escape, zero where there is none
    function automatic logic [7:0] esc_code(input logic [7:0] b);
        logic [7:0] c;
        begin
            unique case (b)
                CH_QUOTE:  c = CH_QUOTE;
                CH_BSLASH: c = CH_BSLASH;
                CH_FF:     c = CH_LOW_F;
                CH_BS:     c = CH_LOW_B;
                CH_CR:     c = CH_LOW_R;
                CH_LF:     c = CH_LOW_N;
                CH_TAB:    c = CH_LOW_T;
                default:   c = CH_NUL;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        begin
            if (n < 4'd10) begin
                return CH_ZERO + {4'h0, n};
            end else begin
                return CH_HEX_AL + {4'h0, n};
            end
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/nsrj_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsrj_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_q_full,
    output logic                o_q_push,
    output nsrj_pkg::t_cmd      o_q_cmd
);
    import nsrj_pkg::*;

    typedef enum logic [4:0] {
        POS_NEW        = 5'b00001,
        POS_NEW_KEY    = 5'b00010,
        POS_KEY_START  = 5'b00100,
        POS_KEY_ECHO   = 5'b01000,
        POS_VALUE_ECHO = 5'b10000
    } t_pos;

    t_pos r_pos;
    t_pos n_pos;
    t_pos eff;
    t_cmd cmd;
    t_cmd esc_cmd;
    logic accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_q_push   = accept;
    assign o_q_cmd    = cmd;

    // body for an ordinary key or value byte
    always_comb begin
        esc_cmd = '0;
        esc_cmd.data = i_in_byte;
        if (esc_code(i_in_byte) != CH_NUL) begin
            esc_cmd.body = BODY_ESC2;
            esc_cmd.data = esc_code(i_in_byte);
        end else if (i_in_byte < CH_SPACE) begin
            esc_cmd.body = BODY_UHEX;
        end else begin
            esc_cmd.body = BODY_RAW;
        end
    end

    always_comb begin
        cmd = esc_cmd;
        eff = POS_NEW_KEY;
        unique case (r_pos)
            POS_NEW_KEY, POS_KEY_START, POS_KEY_ECHO, POS_VALUE_ECHO: begin
                eff = r_pos;
            end
            default: begin
                cmd.lbrace = 1'b1;
                eff = POS_NEW_KEY;
            end
        endcase
        n_pos = eff;
        unique case (eff)
            POS_NEW_KEY, POS_KEY_START: begin
                if (i_in_byte == CH_LF) begin
                    cmd.close = 1'b1;
                    cmd.body  = BODY_NONE;
                    n_pos     = POS_NEW;
                end else begin
                    cmd.comma      = (eff == POS_KEY_START);
                    cmd.open_quote = 1'b1;
                    if (i_in_byte == CH_NUL) begin
                        cmd.body = BODY_KEY_END;
                        n_pos    = POS_VALUE_ECHO;
                    end else begin
                        n_pos = POS_KEY_ECHO;
                    end
                end
            end
            POS_KEY_ECHO: begin
                if (i_in_byte == CH_NUL) begin
                    cmd.body = BODY_KEY_END;
                    n_pos    = POS_VALUE_ECHO;
                end
            end
            default: begin
                if (i_in_byte == CH_NUL) begin
                    cmd.body = BODY_VAL_END;
                    n_pos    = POS_KEY_START;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_NEW;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

// ===== design/nsrj_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsrj_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire nsrj_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_head_valid,
    output nsrj_pkg::t_cmd      o_head
);
    import nsrj_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("word pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== design/nsrj_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsrj_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire nsrj_pkg::t_cmd i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_last_of_run
);
    import nsrj_pkg::*;

    logic [7:0]       run_bytes [MAX_RUN];
    logic [RUN_W-1:0] run_len;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             load;
    logic             at_last;

    // lay out the bytes of the head word in order
    always_comb begin
        logic [RUN_W-1:0] n;
        n = '0;
        for (int k = 0; k < MAX_RUN; k++) begin
            run_bytes[k] = CH_NUL;
        end
        if (i_head.lbrace) begin
            run_bytes[n[IDX_W-1:0]] = CH_LBRACE; n = n + 1'b1;
        end
        if (i_head.close) begin
            run_bytes[n[IDX_W-1:0]] = CH_RBRACE; n = n + 1'b1;
            run_bytes[n[IDX_W-1:0]] = CH_LF;     n = n + 1'b1;
        end
        if (i_head.comma) begin
            run_bytes[n[IDX_W-1:0]] = CH_COMMA; n = n + 1'b1;
        end
        if (i_head.open_quote) begin
            run_bytes[n[IDX_W-1:0]] = CH_QUOTE; n = n + 1'b1;
        end
        unique case (i_head.body)
            BODY_RAW: begin
                run_bytes[n[IDX_W-1:0]] = i_head.data; n = n + 1'b1;
            end
            BODY_ESC2: begin
                run_bytes[n[IDX_W-1:0]] = CH_BSLASH;   n = n + 1'b1;
                run_bytes[n[IDX_W-1:0]] = i_head.data; n = n + 1'b1;
            end
            BODY_UHEX: begin
                run_bytes[n[IDX_W-1:0]] = CH_BSLASH; n = n + 1'b1;
                run_bytes[n[IDX_W-1:0]] = CH_LOW_U;  n = n + 1'b1;
                run_bytes[n[IDX_W-1:0]] = CH_ZERO;   n = n + 1'b1;
                run_bytes[n[IDX_W-1:0]] = CH_ZERO;   n = n + 1'b1;
                run_bytes[n[IDX_W-1:0]] = hex_digit(i_head.data[7:4]); n = n + 1'b1;
                run_bytes[n[IDX_W-1:0]] = hex_digit(i_head.data[3:0]); n = n + 1'b1;
            end
            BODY_KEY_END: begin
                run_bytes[n[IDX_W-1:0]] = CH_QUOTE; n = n + 1'b1;
                run_bytes[n[IDX_W-1:0]] = CH_COLON; n = n + 1'b1;
                run_bytes[n[IDX_W-1:0]] = CH_QUOTE; n = n + 1'b1;
            end
            BODY_VAL_END: begin
                run_bytes[n[IDX_W-1:0]] = CH_QUOTE; n = n + 1'b1;
            end
            default: begin
            end
        endcase
        run_len = n;
    end

    assign load    = i_head_valid && (!r_out_valid || i_out_ready);
    assign at_last = ({1'b0, r_idx} == RUN_W'(run_len - 1'b1));
    assign o_pop   = load && at_last;

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= run_bytes[r_idx];
            r_out_last <= at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= at_last ? '0 : r_idx + 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ({1'b0, r_idx} < run_len))
        else $error("byte index beyond the run of the head word");

    a_run_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (run_len != '0))
        else $error("queued word expands to no bytes");

    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == '0))
        else $error("byte index not restarted after a word is retired");

endmodule

`default_nettype wire

// ===== design/nul_separated_record_to_json.sv =====
// channel | valid       | ready       | payload
// --------+-------------+-------------+-------------------------------
// input   | i_in_valid  | o_in_ready  | i_in_byte
// output  | o_out_valid | i_out_ready | o_out_byte, o_last_of_run
//
// one input byte is taken per cycle while the word queue has room
// each input byte gives 1 to 8 output bytes, sent one per cycle by the back end while i_out_ready is high
// sustained, the input is paced by the output bytes each input byte gives (1 for plain text)
// escape bursts are absorbed by the DEPTH-entry word queue, then the input stalls
// synchronous active-low reset clears the record position, queue and output valid flag
`timescale 1ns / 1ps
`default_nettype none

module nul_separated_record_to_json #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);
    import nsrj_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_cmd;
    logic q_pop;
    logic head_valid;
    t_cmd head;

    nsrj_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_cmd)
    );

    nsrj_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_cmd        (q_cmd),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    nsrj_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire
